// ===== hdl/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, character codes and helpers for the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int MAX_CHARS = 8;

    localparam logic [7:0] LEAD_MASK = 8'he0;
    localparam logic [7:0] LEAD_CODE = 8'hc0;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH     = 8'h2f;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_N         = 8'h6e;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_A         = 8'h61;

    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_LF  = 8'h0a;
    localparam logic [7:0] CTL_FF  = 8'h0c;
    localparam logic [7:0] CTL_CR  = 8'h0d;
    localparam logic [7:0] CTL_END = 8'h20;

    // One classified input item: the characters it expands to, in order.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [3:0]                count;
        logic                      closes;
    } t_desc;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = CH_ZERO + {4'd0, v};
        end else begin
            r = CH_A + {4'd0, v - 4'd10};
        end
        return r;
    endfunction

endpackage

// ===== hdl/json_string_escaper_core.sv =====
// ----------------------------------------------------------------------------
// json_string_escaper_core
// Streaming escaper that turns raw string bytes into quoted JSON text.
// ----------------------------------------------------------------------------
// Input channel: i_valid, o_stall, i_in_byte, i_end_of_string. An item is
// taken at a clock edge with i_valid high and o_stall low. Output channel:
// o_valid, i_stall, o_out_char, o_last, o_closes_string, one character per
// item, taken at an edge with o_valid high and i_stall low.
// Each input item expands to one to eight characters, which pass through
// the queue and the output register. The back end emits one character per
// cycle while i_stall is low, so the output register sets the pace. Plain
// bytes flow at one item per cycle while i_stall is low; an n-character
// item holds the back end until all n are out, and once the QUEUE_DEPTH
// item queue fills o_stall rises until the back end finishes its head item.
// After reset the queue is empty, the output holds no item, and the next
// byte opens a new string. While i_stall is high the presented character
// holds, the queue keeps filling and then stalls the input.
// ----------------------------------------------------------------------------
module json_string_escaper_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_string,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_last,
    output logic       o_closes_string
);

    logic           push;
    logic           pop;
    logic           full;
    logic           q_valid;
    jse_pkg::t_desc f_desc;
    jse_pkg::t_desc q_desc;

    assign o_stall = full;

    jse_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_full          (full),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_push          (push),
        .o_desc          (f_desc)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (f_desc),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    jse_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_desc          (q_desc),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_char      (o_out_char),
        .o_last          (o_last),
        .o_closes_string (o_closes_string)
    );

endmodule

// ===== hdl/jse_front.sv =====
// ----------------------------------------------------------------------------
// jse_front
// Accepts input bytes, tracks string state and builds the escaped expansion.
// ----------------------------------------------------------------------------
module jse_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_full,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_of_string,
    output logic          o_push,
    output jse_pkg::t_desc o_desc
);

    logic r_start;
    logic r_pend;
    logic n_start;
    logic n_pend;
    logic is_lead;

    assign o_push = i_valid && !i_full;

    always_comb begin
        logic [3:0] n;
        jse_pkg::t_desc d;
        logic [7:0] c;
        logic [7:0] e;
        d       = '0;
        n       = 4'd0;
        c       = i_in_byte;
        e       = c;
        is_lead = 1'b0;
        if (r_start) begin
            d.chars[n[2:0]] = jse_pkg::CH_QUOTE; n = n + 4'd1;
        end
        if (r_pend) begin
            d.chars[n[2:0]] = jse_pkg::hex_digit(c[7:4]); n = n + 4'd1;
            d.chars[n[2:0]] = jse_pkg::hex_digit(c[3:0]); n = n + 4'd1;
        end else if (c inside {jse_pkg::CH_QUOTE, jse_pkg::CH_BACKSLASH, jse_pkg::CH_SLASH,
                               jse_pkg::CTL_BS, jse_pkg::CTL_TAB, jse_pkg::CTL_LF,
                               jse_pkg::CTL_FF, jse_pkg::CTL_CR}) begin
            case (c)
                jse_pkg::CTL_BS:  e = jse_pkg::CH_B;
                jse_pkg::CTL_TAB: e = jse_pkg::CH_T;
                jse_pkg::CTL_LF:  e = jse_pkg::CH_N;
                jse_pkg::CTL_FF:  e = jse_pkg::CH_F;
                jse_pkg::CTL_CR:  e = jse_pkg::CH_R;
                default:          e = c;
            endcase
            d.chars[n[2:0]] = jse_pkg::CH_BACKSLASH; n = n + 4'd1;
            d.chars[n[2:0]] = e;                     n = n + 4'd1;
        end else if (c < jse_pkg::CTL_END) begin
            d.chars[n[2:0]] = jse_pkg::CH_BACKSLASH;          n = n + 4'd1;
            d.chars[n[2:0]] = jse_pkg::CH_U;                  n = n + 4'd1;
            d.chars[n[2:0]] = jse_pkg::CH_ZERO;               n = n + 4'd1;
            d.chars[n[2:0]] = jse_pkg::CH_ZERO;               n = n + 4'd1;
            d.chars[n[2:0]] = jse_pkg::hex_digit(c[7:4]);     n = n + 4'd1;
            d.chars[n[2:0]] = jse_pkg::hex_digit(c[3:0]);     n = n + 4'd1;
        end else if ((c & jse_pkg::LEAD_MASK) == jse_pkg::LEAD_CODE) begin
            is_lead = 1'b1;
            d.chars[n[2:0]] = jse_pkg::CH_BACKSLASH;          n = n + 4'd1;
            d.chars[n[2:0]] = jse_pkg::CH_U;                  n = n + 4'd1;
            d.chars[n[2:0]] = jse_pkg::hex_digit(c[7:4]);     n = n + 4'd1;
            d.chars[n[2:0]] = jse_pkg::hex_digit(c[3:0]);     n = n + 4'd1;
            if (i_end_of_string) begin
                d.chars[n[2:0]] = jse_pkg::CH_ZERO;           n = n + 4'd1;
                d.chars[n[2:0]] = jse_pkg::CH_ZERO;           n = n + 4'd1;
            end
        end else begin
            d.chars[n[2:0]] = c; n = n + 4'd1;
        end
        if (i_end_of_string) begin
            d.chars[n[2:0]] = jse_pkg::CH_QUOTE; n = n + 4'd1;
            d.closes = 1'b1;
        end
        d.count = n;
        o_desc  = d;
    end

    always_comb begin
        n_start = r_start;
        n_pend  = r_pend;
        if (o_push) begin
            n_start = i_end_of_string;
            n_pend  = is_lead && !i_end_of_string;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b1;
            r_pend  <= 1'b0;
        end else begin
            r_start <= n_start;
            r_pend  <= n_pend;
        end
    end

    a_pend_not_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_start)
        else $error("Pending second byte while at string start.");

    a_desc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_desc.count != 4'd0 && o_desc.count <= 4'd8))
        else $error("Item expansion has an impossible length.");

endmodule

// ===== hdl/jse_queue.sv =====
// ----------------------------------------------------------------------------
// jse_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module jse_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jse_pkg::t_desc i_desc,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output jse_pkg::t_desc o_desc
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jse_pkg::t_desc r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr;
    logic [AW-1:0]  n_rd;
    logic [CW-1:0]  n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("Queue read while empty.");

endmodule

// ===== hdl/jse_back.sv =====
// ----------------------------------------------------------------------------
// jse_back
// Walks the head item of the queue, one character per cycle unless stalled.
// ----------------------------------------------------------------------------
module jse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  jse_pkg::t_desc i_desc,
    output logic           o_pop,
    input  logic           i_stall,
    output logic           o_valid,
    output logic [7:0]     o_out_char,
    output logic           o_last,
    output logic           o_closes_string
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       r_closes;
    logic [2:0] r_idx;
    logic       n_valid;
    logic [2:0] n_idx;
    logic       advance;
    logic       is_last;

    assign advance = !r_valid || !i_stall;
    assign is_last = ({1'b0, r_idx} + 4'd1) == i_desc.count;
    assign o_pop   = advance && i_q_valid && is_last;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (advance) begin
            n_valid = i_q_valid;
            if (i_q_valid) begin
                n_idx = is_last ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_q_valid) begin
            r_char   <= i_desc.chars[r_idx];
            r_last   <= is_last;
            r_closes <= is_last && i_desc.closes;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_char      = r_char;
    assign o_last          = r_last;
    assign o_closes_string = r_closes;

    a_close_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_closes |-> r_last)
        else $error("Closing quote is not the last character of its item.");

    a_idx_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 3'd0 |-> i_q_valid)
        else $error("Item lost in the middle of its expansion.");

endmodule

// ===== sim/tb_json_string_escaper_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_escaper_core
// Self-checking bench for the streaming JSON string escaper.
// A directed set of strings covers every escape class, two-byte lead bytes
// and string ends. Random strings follow, mostly well-formed text with some
// raw noise. The sender works in bursts and the receiver stalls in changing
// patterns. Every character that comes out is checked against a software
// escaper running beside the block.
// ----------------------------------------------------------------------------
module tb_json_string_escaper_core;

    localparam int RANDOM_ITEMS = 160;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [7:0] data;
        logic       eos;
    } t_str_byte;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       closes;
    } t_esc_char;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_string = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_out_char;
    logic       o_last;
    logic       o_closes_string;

    t_str_byte   raw_bytes[$];
    t_esc_char   expected_text[$];
    logic        opening_quote_due = 1'b1;
    logic        awaiting_trail_byte = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_phase = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          idle_cycles = 0;
    int          mismatches = 0;

    json_string_escaper_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_char      (o_out_char),
        .o_last          (o_last),
        .o_closes_string (o_closes_string)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        if (n > 4'd9) begin
            return jse_pkg::CH_A - 8'd10 + {4'h0, n};
        end
        return jse_pkg::CH_ZERO + {4'h0, n};
    endfunction

    task automatic escape_byte(input t_str_byte it);
        logic [7:0] chars[$];
        t_esc_char  ec;
        int         i;
        if (opening_quote_due) begin
            chars.push_back(jse_pkg::CH_QUOTE);
            opening_quote_due = 1'b0;
        end
        if (awaiting_trail_byte) begin
            chars.push_back(nibble_char(it.data[7:4]));
            chars.push_back(nibble_char(it.data[3:0]));
            awaiting_trail_byte = 1'b0;
        end else begin
            case (it.data)
                jse_pkg::CH_QUOTE, jse_pkg::CH_BACKSLASH, jse_pkg::CH_SLASH: begin
                    chars.push_back(jse_pkg::CH_BACKSLASH);
                    chars.push_back(it.data);
                end
                jse_pkg::CTL_BS: begin
                    chars.push_back(jse_pkg::CH_BACKSLASH);
                    chars.push_back(jse_pkg::CH_B);
                end
                jse_pkg::CTL_TAB: begin
                    chars.push_back(jse_pkg::CH_BACKSLASH);
                    chars.push_back(jse_pkg::CH_T);
                end
                jse_pkg::CTL_LF: begin
                    chars.push_back(jse_pkg::CH_BACKSLASH);
                    chars.push_back(jse_pkg::CH_N);
                end
                jse_pkg::CTL_FF: begin
                    chars.push_back(jse_pkg::CH_BACKSLASH);
                    chars.push_back(jse_pkg::CH_F);
                end
                jse_pkg::CTL_CR: begin
                    chars.push_back(jse_pkg::CH_BACKSLASH);
                    chars.push_back(jse_pkg::CH_R);
                end
                default: begin
                    if (it.data < jse_pkg::CTL_END) begin
                        chars.push_back(jse_pkg::CH_BACKSLASH);
                        chars.push_back(jse_pkg::CH_U);
                        chars.push_back(jse_pkg::CH_ZERO);
                        chars.push_back(jse_pkg::CH_ZERO);
                        chars.push_back(nibble_char(it.data[7:4]));
                        chars.push_back(nibble_char(it.data[3:0]));
                    end else if ((it.data & jse_pkg::LEAD_MASK) == jse_pkg::LEAD_CODE) begin
                        chars.push_back(jse_pkg::CH_BACKSLASH);
                        chars.push_back(jse_pkg::CH_U);
                        chars.push_back(nibble_char(it.data[7:4]));
                        chars.push_back(nibble_char(it.data[3:0]));
                        if (it.eos) begin
                            chars.push_back(jse_pkg::CH_ZERO);
                            chars.push_back(jse_pkg::CH_ZERO);
                        end else begin
                            awaiting_trail_byte = 1'b1;
                        end
                    end else begin
                        chars.push_back(it.data);
                    end
                end
            endcase
        end
        if (it.eos) begin
            chars.push_back(jse_pkg::CH_QUOTE);
            opening_quote_due = 1'b1;
            awaiting_trail_byte = 1'b0;
        end
        for (i = 0; i < chars.size(); i++) begin
            ec.ch     = chars[i];
            ec.last   = (i == chars.size() - 1);
            ec.closes = it.eos && (i == chars.size() - 1);
            expected_text.push_back(ec);
        end
    endtask

    task automatic add_byte(input logic [7:0] data, input logic eos);
        t_str_byte it;
        it.data = data;
        it.eos  = eos;
        raw_bytes.push_back(it);
    endtask

    always @(posedge i_clk) begin : feed
        logic take;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            take = i_valid && !o_stall;
            if (take) begin
                escape_byte(raw_bytes.pop_front());
            end
            if (i_valid && !take) begin
                // The stalled item holds.
            end else if (gap_left != 0 || raw_bytes.size() == 0) begin
                i_valid <= 1'b0;
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end
            end else begin
                i_valid         <= 1'b1;
                i_in_byte       <= raw_bytes[0].data;
                i_end_of_string <= raw_bytes[0].eos;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_phase == 0) begin
                stall_mode  <= t_stall_mode'($urandom_range(0, 3));
                stall_phase <= $urandom_range(20, 80);
            end else begin
                stall_phase <= stall_phase - 1;
            end
            case (stall_mode)
                STALL_NONE:  i_stall <= ($urandom_range(0, 3) == 4);
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default:     i_stall <= ((stall_phase % 7) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin : check
        t_esc_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_text.size() == 0) begin
                $error("unexpected character %h with nothing expected", o_out_char);
                mismatches++;
            end else begin
                want = expected_text.pop_front();
                if (o_out_char !== want.ch) begin
                    $error("o_out_char: expected %h, got %h", want.ch, o_out_char);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("o_last: expected %b, got %b", want.last, o_last);
                    mismatches++;
                end
                if (o_closes_string !== want.closes) begin
                    $error("o_closes_string: expected %b, got %b", want.closes,
                           o_closes_string);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [7:0] escapes[8];
        logic [7:0] b;
        int         target;
        int         len;
        int         k;
        int         kind;

        escapes = '{jse_pkg::CH_QUOTE, jse_pkg::CH_BACKSLASH, jse_pkg::CH_SLASH,
                    jse_pkg::CTL_BS, jse_pkg::CTL_TAB, jse_pkg::CTL_LF,
                    jse_pkg::CTL_FF, jse_pkg::CTL_CR};

        // Directed strings: escape classes, lead bytes, and string ends.
        add_byte(8'h41, 1'b1);
        add_byte(jse_pkg::CH_QUOTE, 1'b0);
        add_byte(jse_pkg::CH_BACKSLASH, 1'b0);
        add_byte(jse_pkg::CH_SLASH, 1'b0);
        add_byte(jse_pkg::CTL_BS, 1'b0);
        add_byte(jse_pkg::CTL_TAB, 1'b0);
        add_byte(jse_pkg::CTL_LF, 1'b0);
        add_byte(jse_pkg::CTL_FF, 1'b0);
        add_byte(jse_pkg::CTL_CR, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h1f, 1'b0);
        add_byte(8'h20, 1'b0);
        add_byte(8'hc0, 1'b0);
        add_byte(jse_pkg::CH_QUOTE, 1'b0);
        add_byte(8'hdf, 1'b0);
        add_byte(8'hff, 1'b1);
        add_byte(8'hc5, 1'b1);
        add_byte(8'he0, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h7f, 1'b0);
        add_byte(8'hff, 1'b1);
        add_byte(8'h0b, 1'b1);

        target = raw_bytes.size() + RANDOM_ITEMS;
        while (raw_bytes.size() < target) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
            k = 0;
            while (k < len) begin
                kind = $urandom_range(0, 9);
                if (kind == 6 || kind == 7) begin
                    add_byte(jse_pkg::LEAD_CODE | 8'($urandom_range(0, 31)), k == len - 1);
                    k++;
                    if (k < len) begin
                        if ($urandom_range(0, 9) == 0) begin
                            b = 8'($urandom_range(0, 255));
                        end else begin
                            b = 8'($urandom_range(8'h80, 8'hbf));
                        end
                        add_byte(b, k == len - 1);
                        k++;
                    end
                end else begin
                    case (kind)
                        4:       b = escapes[3'($urandom_range(0, 7))];
                        5:       b = 8'($urandom_range(0, 31));
                        8:       b = 8'($urandom_range(128, 255));
                        9:       b = 8'($urandom_range(0, 255));
                        default: b = 8'($urandom_range(32, 126));
                    endcase
                    add_byte(b, k == len - 1);
                    k++;
                end
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (raw_bytes.size() != 0 || i_valid || expected_text.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_text.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/jse_pkg.sv
hdl/jse_front.sv
hdl/jse_queue.sv
hdl/jse_back.sv
hdl/json_string_escaper_core.sv
sim/tb_json_string_escaper_core.sv
